[sv/xee_pkg.sv]
`timescale 1ns / 1ps
// xee_pkg: shared types, codes and entity tables of the xml entity escaper
package xee_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned USED_W         = 16;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // register indexes
  localparam logic REG_CAPACITY      = 1'b0;
  localparam logic REG_DOUBLE_ESCAPE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_TERM = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  // entity codes
  localparam logic [2:0] ENT_LT   = 3'd0;
  localparam logic [2:0] ENT_GT   = 3'd1;
  localparam logic [2:0] ENT_AMP  = 3'd2;
  localparam logic [2:0] ENT_QUOT = 3'd3;
  localparam logic [2:0] ENT_APOS = 3'd4;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_AMP = 8'h26;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_TERM,
    JOB_OVF,
    JOB_ENT
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [7:0]  data;
    logic [2:0]  ent;
    logic        dbl;
  } job_t;

  // body length of an entity, without the leading ampersand
  function automatic logic [3:0] body_len(logic [2:0] e);
    logic [3:0] n;
    case (e)
      ENT_LT:   n = 4'd3;
      ENT_GT:   n = 4'd3;
      ENT_AMP:  n = 4'd4;
      ENT_QUOT: n = 4'd5;
      ENT_APOS: n = 4'd5;
      default:  n = 4'd5;
    endcase
    return n;
  endfunction

  // total bytes written for an entity
  function automatic logic [3:0] ent_len(logic [2:0] e, logic dbl);
    return 4'd1 + (dbl ? 4'd4 : 4'd0) + body_len(e);
  endfunction

  function automatic logic [7:0] body_char(logic [2:0] e, logic [2:0] k);
    logic [39:0] s;
    logic [7:0]  ch;
    case (e)
      ENT_LT:   s = "lt;  ";
      ENT_GT:   s = "gt;  ";
      ENT_AMP:  s = "amp; ";
      ENT_QUOT: s = "quot;";
      ENT_APOS: s = "apos;";
      default:  s = "apos;";
    endcase
    case (k)
      3'd0:    ch = s[39:32];
      3'd1:    ch = s[31:24];
      3'd2:    ch = s[23:16];
      3'd3:    ch = s[15:8];
      default: ch = s[7:0];
    endcase
    return ch;
  endfunction

  // byte at position idx of the expanded entity
  function automatic logic [7:0] ent_char(logic [2:0] e, logic dbl, logic [3:0] idx);
    logic [7:0] ch;
    logic [3:0] k;
    if (idx == 4'd0) begin
      ch = CHAR_AMP;
    end else if (dbl && (idx <= 4'd4)) begin
      k  = idx - 4'd1;
      ch = body_char(ENT_AMP, k[2:0]);
    end else begin
      k  = idx - 4'd1 - (dbl ? 4'd4 : 4'd0);
      ch = body_char(e, k[2:0]);
    end
    return ch;
  endfunction

endpackage

[sv/xee_front.sv]
`timescale 1ns / 1ps
// xee_front: accepts source bytes, classifies them, checks capacity and queues jobs
module xee_front import xee_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  input  logic [15:0]           capacity_i,
  input  logic                  double_escape_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output job_t                  push_job_o,
  output logic [COUNT_BITS-1:0] push_cnt_o
);

  localparam int unsigned W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] used_q, used_d;
  logic                  aborted_q, aborted_d;

  logic       accept;
  logic       is_ent;
  logic [2:0] ent;
  logic [3:0] n;
  logic [W-1:0] cap_w, max_w, lim;
  logic [W:0]   need;
  logic         fits;
  job_t         job;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_ent = 1'b1;
    ent    = ENT_LT;
    case (in_byte_i)
      "<":     ent = ENT_LT;
      ">":     ent = ENT_GT;
      "&":     ent = ENT_AMP;
      "\"":    ent = ENT_QUOT;
      "'":     ent = ENT_APOS;
      default: is_ent = 1'b0;
    endcase
  end

  always_comb begin
    n     = is_ent ? ent_len(ent, double_escape_i) : 4'd1;
    cap_w = W'(capacity_i);
    max_w = {W{1'b1}} >> (W - COUNT_BITS);
    lim   = (cap_w < max_w) ? cap_w : max_w;
    need  = (W+1)'(used_q) + (W+1)'(n);
    fits  = need <= {1'b0, lim};
  end

  always_comb begin
    used_d    = used_q;
    aborted_d = aborted_q;
    job.op    = JOB_DATA;
    job.data  = in_byte_i;
    job.ent   = ent;
    job.dbl   = double_escape_i;
    if (accept) begin
      if (aborted_q) begin
        if (in_byte_i == CHAR_NUL) begin
          aborted_d = 1'b0;
          used_d    = '0;
        end
      end else if (!fits) begin
        job.op = JOB_OVF;
        if (!is_ent && (in_byte_i == CHAR_NUL)) begin
          used_d = '0;
        end else begin
          aborted_d = 1'b1;
        end
      end else if (is_ent) begin
        job.op = JOB_ENT;
        used_d = used_q + COUNT_BITS'(n);
      end else if (in_byte_i == CHAR_NUL) begin
        job.op = JOB_TERM;
        used_d = '0;
      end else begin
        used_d = used_q + COUNT_BITS'(1);
      end
    end
  end

  assign push_o     = accept && !aborted_q;
  assign push_job_o = job;
  assign push_cnt_o = used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      aborted_q <= 1'b0;
    end else begin
      used_q    <= used_d;
      aborted_q <= aborted_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_ovf_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (job.op == JOB_OVF) && (in_byte_i != CHAR_NUL) |=> aborted_q)
    else $error("overflow did not abort the string");
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_byte_i == CHAR_NUL) |=> (used_q == '0) && !aborted_q)
    else $error("terminator did not clear the string state");
`endif

endmodule

[sv/xee_fifo.sv]
`timescale 1ns / 1ps
// xee_fifo: short job queue between the front and the back
module xee_fifo import xee_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  job_t                  push_job_i,
  input  logic [COUNT_BITS-1:0] push_cnt_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output job_t                  head_job_o,
  output logic [COUNT_BITS-1:0] head_cnt_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

  job_t                  job_mem [FIFO_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [FIFO_DEPTH];

  logic [PTR_W-1:0] wr_q, rd_q;
  logic [LVL_W-1:0] lvl_q;

  assign full_o       = lvl_q == LVL_W'(FIFO_DEPTH);
  assign head_valid_o = lvl_q != '0;
  assign head_job_o   = job_mem[rd_q];
  assign head_cnt_o   = cnt_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_mem[wr_q] <= push_job_i;
      cnt_mem[wr_q] <= push_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        lvl_q <= lvl_q + LVL_W'(1);
      end else if (pop_i && !push_i) begin
        lvl_q <= lvl_q - LVL_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("push into a full job queue");
`endif

endmodule

[sv/xee_back.sv]
`timescale 1ns / 1ps
// xee_back: expands queued jobs into output beats behind an output register
module xee_back import xee_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  job_t                  head_job_i,
  input  logic [COUNT_BITS-1:0] head_cnt_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            status_o,
  output logic                  last_o,
  output logic [USED_W-1:0]     used_count_o
);

  localparam int unsigned W = (COUNT_BITS > USED_W) ? COUNT_BITS : USED_W;

  logic       out_valid_q;
  logic [3:0] idx_q;

  logic [7:0]        byte_q;
  logic [1:0]        status_q;
  logic              last_q;
  logic [USED_W-1:0] used_q;

  logic                  emit;
  logic [3:0]            len;
  logic                  last_beat;
  logic [7:0]            beat_byte;
  logic [1:0]            beat_status;
  logic [COUNT_BITS-1:0] beat_cnt;
  logic [W-1:0]          beat_cnt_w;

  always_comb begin
    len         = (head_job_i.op == JOB_ENT) ? ent_len(head_job_i.ent, head_job_i.dbl) : 4'd1;
    last_beat   = idx_q == (len - 4'd1);
    emit        = head_valid_i && (!out_valid_q || out_ready_i);
    beat_byte   = head_job_i.data;
    beat_status = STATUS_DATA;
    beat_cnt    = head_cnt_i + COUNT_BITS'(idx_q) + COUNT_BITS'(1);
    unique case (head_job_i.op)
      JOB_DATA: ;
      JOB_TERM: begin
        beat_byte   = CHAR_NUL;
        beat_status = STATUS_TERM;
      end
      JOB_OVF: begin
        beat_byte   = CHAR_NUL;
        beat_status = STATUS_OVF;
        beat_cnt    = head_cnt_i;
      end
      JOB_ENT: beat_byte = ent_char(head_job_i.ent, head_job_i.dbl, idx_q);
    endcase
    beat_cnt_w = W'(beat_cnt);
  end

  assign pop_o = emit && last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        idx_q       <= last_beat ? 4'd0 : idx_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q   <= beat_byte;
      status_q <= beat_status;
      last_q   <= last_beat;
      used_q   <= beat_cnt_w[USED_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign status_o     = status_q;
  assign last_o       = last_q;
  assign used_count_o = used_q;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < len)
    else $error("beat index past the end of the job");
  a_ovf_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == STATUS_OVF) |-> last_q && (byte_q == CHAR_NUL))
    else $error("overflow beat is not a single zero beat");
`endif

endmodule

[sv/xml_entity_escaper.sv]
`timescale 1ns / 1ps
// xml_entity_escaper: top level with configuration registers, front, job queue and back
// Escapes a byte stream for XML: < > & " ' become &lt; &gt; &amp; &quot; &apos;,
// with the leading & written again as &amp; when double_escape is set. A zero byte
// ends the string and clears the per-string count; an entity or byte that would
// exceed capacity gives one overflow beat and the rest of the string is dropped.
// The front takes one source byte per cycle while the four-entry job queue has
// room; the back emits one output beat per cycle while the output is taken, so a
// plain byte gives one beat and an entity one beat per output byte (4 to 10),
// which sets the sustained rate for entity-heavy text. Output beats sit in a
// register, so input and output stall independently.
module xml_entity_escaper import xee_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            status_o,
  output logic                  last_o,
  output logic [USED_W-1:0]     used_count_o
);

  logic [15:0] capacity_q;
  logic        double_escape_q;

  logic                  push, full, pop, head_valid;
  job_t                  push_job, head_job;
  logic [COUNT_BITS-1:0] push_cnt, head_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q      <= CAPACITY_RESET;
      double_escape_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAPACITY:      capacity_q      <= cfg_wdata_i[15:0];
        REG_DOUBLE_ESCAPE: double_escape_q <= cfg_wdata_i[0];
      endcase
    end
  end

  xee_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .capacity_i      (capacity_q),
    .double_escape_i (double_escape_q),
    .fifo_full_i     (full),
    .push_o          (push),
    .push_job_o      (push_job),
    .push_cnt_o      (push_cnt)
  );

  xee_fifo #(.COUNT_BITS(COUNT_BITS)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_job_i   (push_job),
    .push_cnt_i   (push_cnt),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .head_cnt_o   (head_cnt)
  );

  xee_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .head_cnt_i   (head_cnt),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .status_o,
    .last_o,
    .used_count_o
  );

endmodule

[sim/tb_xml_entity_escaper.sv]
`timescale 1ns / 1ps
// tb_xml_entity_escaper: self-checking testbench of the xml entity escaper with queued stimulus
module tb_xml_entity_escaper;
  import xee_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0]        ch;
    logic [1:0]        st;
    logic              lst;
    logic [USED_W-1:0] used;
  } beat_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic                  cfg_idx_i    = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            in_byte_i    = CHAR_NUL;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [7:0]            out_byte_o;
  logic [1:0]            status_o;
  logic                  last_o;
  logic [USED_W-1:0]     used_count_o;

  // pending source bytes and expected output beats
  logic [7:0]  text_q[$];
  beat_t       escaped_q[$];

  // shadow of the configuration and the per-string state
  logic [15:0] capacity_sh = CAPACITY_RESET;
  logic        dbl_sh      = 1'b0;
  int          used_sh     = 0;
  logic        aborted_sh  = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned queued_items = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  logic        hold_go = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;

  logic [7:0] specials[5] = '{"<", ">", "&", "\"", "'"};

  xml_entity_escaper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .used_count_o (used_count_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic emit(input logic [7:0] ch, input logic [1:0] st, input logic lst);
    beat_t b;
    b.ch   = ch;
    b.st   = st;
    b.lst  = lst;
    b.used = used_sh[USED_W-1:0];
    escaped_q.push_back(b);
  endtask

  // overflow beat; a rejected terminator starts a fresh string
  task automatic reject(input logic is_term);
    emit(CHAR_NUL, STATUS_OVF, 1'b1);
    if (is_term) begin
      used_sh = 0;
    end else begin
      aborted_sh = 1'b1;
    end
  endtask

  task automatic escape_byte(input logic [7:0] ch);
    string body;
    string text;
    if (aborted_sh) begin
      if (ch == CHAR_NUL) begin
        aborted_sh = 1'b0;
        used_sh    = 0;
      end
      return;
    end
    case (ch)
      "<":     body = "lt;";
      ">":     body = "gt;";
      "&":     body = "amp;";
      "\"":    body = "quot;";
      "'":     body = "apos;";
      default: body = "";
    endcase
    if (body.len() != 0) begin
      text = dbl_sh ? {"&amp;", body} : {"&", body};
      if (used_sh + text.len() > capacity_sh) begin
        reject(1'b0);
      end else begin
        for (int i = 0; i < text.len(); i++) begin
          used_sh++;
          emit(text[i], STATUS_DATA, i == text.len() - 1);
        end
      end
    end else if (used_sh + 1 > capacity_sh) begin
      reject(ch == CHAR_NUL);
    end else begin
      used_sh++;
      if (ch == CHAR_NUL) begin
        emit(CHAR_NUL, STATUS_TERM, 1'b1);
        used_sh = 0;
      end else begin
        emit(ch, STATUS_DATA, 1'b1);
      end
    end
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= CHAR_NUL;
    end else if (!in_valid_i || in_ready_o) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_byte_i  <= text_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // sink side with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // predict on each input beat, then check each output beat
  always @(posedge clk_i) begin
    beat_t exp_b;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        escape_byte(in_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (escaped_q.size() == 0) begin
          $error("unexpected beat: out_byte %0h status %0d", out_byte_o, status_o);
          err_cnt++;
        end else begin
          exp_b = escaped_q.pop_front();
          if (out_byte_o !== exp_b.ch) begin
            $error("out_byte: expected %0h, got %0h", exp_b.ch, out_byte_o);
            err_cnt++;
          end
          if (status_o !== exp_b.st) begin
            $error("status: expected %0d, got %0d", exp_b.st, status_o);
            err_cnt++;
          end
          if (last_o !== exp_b.lst) begin
            $error("last: expected %0d, got %0d", exp_b.lst, last_o);
            err_cnt++;
          end
          if (used_count_o !== exp_b.used) begin
            $error("used_count: expected %0d, got %0d", exp_b.used, used_count_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CAPACITY) begin
      capacity_sh = val;
    end else begin
      dbl_sh = val[0];
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (text_q.size() != 0 || in_valid_i || escaped_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one string of mostly plain text and entity characters
  task automatic queue_string();
    int unsigned len;
    int unsigned r;
    len = $urandom_range(24);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        text_q.push_back(specials[$urandom_range(4)]);
      end else if (r < 42) begin
        text_q.push_back(8'($urandom_range(255)));
      end else begin
        text_q.push_back(8'($urandom_range(126, 32)));
      end
      queued_items++;
    end
    if ($urandom_range(99) < 85) begin
      text_q.push_back(CHAR_NUL);
      queued_items++;
    end
  endtask

  task automatic run_phase(input logic [15:0] cap, input logic dbl, input int unsigned s_pct,
                           input int unsigned r_pct, input int unsigned n, input logic stall);
    int unsigned goal;
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_DOUBLE_ESCAPE, {15'd0, dbl});
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    goal = queued_items + n;
    if (stall) begin
      hold_go = 1'b1;
    end
    while (queued_items < goal) begin
      wait (text_q.size() < 8);
      queue_string();
      @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every entity and byte extremes
    foreach (specials[i]) text_q.push_back(specials[i]);
    text_q.push_back(8'h01);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h7F);
    text_q.push_back(8'h80);
    text_q.push_back("A");
    text_q.push_back(CHAR_NUL);
    drain();

    // capacity of one: overflow, dropped bytes, terminator not fitting
    write_reg(REG_CAPACITY, 16'd1);
    write_reg(REG_DOUBLE_ESCAPE, 16'd1);
    text_q.push_back(CHAR_NUL);
    text_q.push_back("a");
    text_q.push_back("b");
    text_q.push_back("c");
    text_q.push_back(CHAR_NUL);
    text_q.push_back("<");
    text_q.push_back(CHAR_NUL);
    text_q.push_back("x");
    text_q.push_back(CHAR_NUL);
    text_q.push_back("y");
    text_q.push_back(CHAR_NUL);
    drain();

    run_phase(16'hFFFF, 1'b0, 0, 0, 55, 1'b1);
    run_phase(16'd12, 1'b1, 56, 0, 55, 1'b0);
    run_phase(16'd7, 1'b0, 0, 56, 55, 1'b0);
    run_phase(16'd30, 1'b1, 6, 6, 55, 1'b0);
    run_phase(16'd1, 1'b0, 0, 0, 55, 1'b0);
    run_phase(16'($urandom_range(40, 2)), 1'($urandom_range(1)), 56, 0, 55, 1'b0);
    run_phase(16'hFFFF, 1'b1, 0, 56, 55, 1'b0);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
sv/xee_pkg.sv
sv/xee_front.sv
sv/xee_fifo.sv
sv/xee_back.sv
sv/xml_entity_escaper.sv
sim/tb_xml_entity_escaper.sv
